@@ rtl/ptq_pkg.sv @@
// Package for the periodic timer queue: table size, request and status codes,
// and the command and read structs passed between the sequencer and the table.
// No dependencies.
package ptq_pkg;

	localparam int MAX_TIMERS = 16;
	localparam int IDX_W      = $clog2(MAX_TIMERS);
	localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
	localparam int TIME_W     = 48;
	localparam int PER_W      = 32;
	localparam int ID_W       = 16;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_CHECK  = 2'd2;
	localparam logic [1:0] REQ_NONE   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic              add;
		logic              free;
		logic              rearm;
		logic [IDX_W-1:0]  idx;
		logic [TIME_W-1:0] deadline;
		logic [PER_W-1:0]  period;
		logic [ID_W-1:0]   id;
	} tbl_cmd_t;

	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] deadline;
		logic [PER_W-1:0]  period;
		logic [ID_W-1:0]   id;
		logic [IDX_W-1:0]  order;
	} tbl_rd_t;

endpackage

@@ rtl/ptq_table.sv @@
// Timer slot table: valid bits, deadlines, periods, ids and entry ranks,
// with one read port and add, free and re-arm commands.
// Depends on ptq_pkg.
module ptq_table (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ptq_pkg::tbl_cmd_t        cmd,
	input  logic [ptq_pkg::IDX_W-1:0] rd_idx,
	output ptq_pkg::tbl_rd_t         rd,
	output logic                     free_found,
	output logic [ptq_pkg::IDX_W-1:0] free_idx
);

	logic [ptq_pkg::MAX_TIMERS-1:0] valid_q;
	logic [ptq_pkg::TIME_W-1:0]     deadline_q [ptq_pkg::MAX_TIMERS];
	logic [ptq_pkg::PER_W-1:0]      period_q   [ptq_pkg::MAX_TIMERS];
	logic [ptq_pkg::ID_W-1:0]       id_q       [ptq_pkg::MAX_TIMERS];
	logic [ptq_pkg::IDX_W-1:0]      order_q    [ptq_pkg::MAX_TIMERS];
	logic [ptq_pkg::CNT_W-1:0]      count_q;
	logic [ptq_pkg::IDX_W-1:0]      cmd_rank;

	assign rd.valid    = valid_q[rd_idx];
	assign rd.deadline = deadline_q[rd_idx];
	assign rd.period   = period_q[rd_idx];
	assign rd.id       = id_q[rd_idx];
	assign rd.order    = order_q[rd_idx];
	assign cmd_rank    = order_q[cmd.idx];

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int k = ptq_pkg::MAX_TIMERS - 1; k >= 0; k--) begin
			if (!valid_q[k]) begin
				free_found = 1'b1;
				free_idx   = ptq_pkg::IDX_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.add) begin
				valid_q[cmd.idx] <= 1'b1;
				count_q          <= count_q + 1'b1;
			end else if (cmd.free) begin
				valid_q[cmd.idx] <= 1'b0;
				if (count_q != '0)
					count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add) begin
			deadline_q[cmd.idx] <= cmd.deadline;
			period_q[cmd.idx]   <= cmd.period;
			id_q[cmd.idx]       <= cmd.id;
			order_q[cmd.idx]    <= count_q[ptq_pkg::IDX_W-1:0];
		end else if (cmd.free || cmd.rearm) begin
			// close the gap left in the rank sequence
			for (int k = 0; k < ptq_pkg::MAX_TIMERS; k++) begin
				if (ptq_pkg::IDX_W'(k) != cmd.idx && valid_q[k] && order_q[k] > cmd_rank)
					order_q[k] <= order_q[k] - 1'b1;
			end
			if (cmd.rearm) begin
				deadline_q[cmd.idx] <= cmd.deadline;
				order_q[cmd.idx]    <= ptq_pkg::IDX_W'(count_q - 1'b1);
			end
		end
	end

endmodule

@@ rtl/periodic_timer_queue.sv @@
// Periodic timer queue top level: request sequencer, earliest-deadline scan and
// result registers around the slot table.
// Depends on ptq_pkg and ptq_table.
//
//  channel  | handshake              | ports
//  ---------+------------------------+---------------------------------------------
//  request  | start & !busy          | req_type now_ms deadline_ms period_ms
//           |                        | cancel_id handler_stop
//  result   | done, one cycle        | status new_id fired fired_id armed
//           |                        | next_deadline_ms
//
// Each request walks the table one slot a cycle through a single compare unit.
// Add takes a free slot and then scans; remove walks every slot and then scans; check
// scans, fires the earliest due timer and scans again if it fired; request code 3 only scans.
// busy is low from the cycle done is high; reset empties the table at once.
// The receiver cannot stall: done marks each result for one cycle only.
module periodic_timer_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [ptq_pkg::TIME_W-1:0]    now_ms,
	input  logic [ptq_pkg::TIME_W-1:0]    deadline_ms,
	input  logic [ptq_pkg::PER_W-1:0]     period_ms,
	input  logic [ptq_pkg::ID_W-1:0]      cancel_id,
	input  logic                          handler_stop,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [ptq_pkg::ID_W-1:0]      new_id,
	output logic                          fired,
	output logic [ptq_pkg::ID_W-1:0]      fired_id,
	output logic                          armed,
	output logic [ptq_pkg::TIME_W-1:0]    next_deadline_ms
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_REMOVE,
		S_SCAN_PRE,
		S_FIRE,
		S_SCAN,
		S_RESP
	} state_t;

	state_t                         state_q;
	logic [ptq_pkg::TIME_W-1:0]     now_q;
	logic [ptq_pkg::TIME_W-1:0]     deadline_q;
	logic [ptq_pkg::PER_W-1:0]      period_q;
	logic [ptq_pkg::ID_W-1:0]       cid_q;
	logic                           stop_q;
	logic [ptq_pkg::ID_W-1:0]       last_id_q;
	logic [ptq_pkg::IDX_W-1:0]      idx_q;
	logic                           found_q;
	logic                           best_hit_q;
	logic [ptq_pkg::IDX_W-1:0]      best_idx_q;
	logic [ptq_pkg::TIME_W-1:0]     best_dl_q;
	logic [ptq_pkg::IDX_W-1:0]      best_ord_q;

	logic                           done_q;
	logic [1:0]                     status_q;
	logic [ptq_pkg::ID_W-1:0]       new_id_q;
	logic                           fired_q;
	logic [ptq_pkg::ID_W-1:0]       fired_id_q;
	logic                           armed_q;
	logic [ptq_pkg::TIME_W-1:0]     next_dl_q;

	ptq_pkg::tbl_cmd_t              cmd;
	ptq_pkg::tbl_rd_t               rd;
	logic [ptq_pkg::IDX_W-1:0]      rd_idx;
	logic                           free_found;
	logic [ptq_pkg::IDX_W-1:0]      free_idx;

	logic                           last_slot;
	logic                           better;
	logic                           rm_hit;
	logic                           due;
	logic                           release_slot;
	logic [ptq_pkg::ID_W-1:0]       next_id;
	logic [ptq_pkg::TIME_W:0]       rearm_sum;
	logic [ptq_pkg::TIME_W-1:0]     rearm_dl;

	ptq_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rd_idx     (rd_idx),
		.rd         (rd),
		.free_found (free_found),
		.free_idx   (free_idx)
	);

	assign busy             = (state_q != S_IDLE);
	assign done             = done_q;
	assign status           = status_q;
	assign new_id           = new_id_q;
	assign fired            = fired_q;
	assign fired_id         = fired_id_q;
	assign armed            = armed_q;
	assign next_deadline_ms = next_dl_q;

	assign rd_idx    = (state_q == S_FIRE) ? best_idx_q : idx_q;
	assign last_slot = (idx_q == ptq_pkg::IDX_W'(ptq_pkg::MAX_TIMERS - 1));
	assign better    = rd.valid && (!best_hit_q || rd.deadline < best_dl_q ||
		(rd.deadline == best_dl_q && rd.order < best_ord_q));
	assign rm_hit    = rd.valid && rd.id == cid_q && cid_q != '0;
	assign due       = best_hit_q && best_dl_q <= now_q;
	assign release_slot = (rd.period == '0) || stop_q;
	assign next_id   = (last_id_q + 1'b1 == '0) ? ptq_pkg::ID_W'(1) : last_id_q + 1'b1;
	assign rearm_sum = {1'b0, now_q} + {{(ptq_pkg::TIME_W + 1 - ptq_pkg::PER_W){1'b0}}, rd.period};
	assign rearm_dl  = rearm_sum[ptq_pkg::TIME_W] ? '1 : rearm_sum[ptq_pkg::TIME_W-1:0];

	always_comb begin
		cmd          = '0;
		cmd.deadline = deadline_q;
		cmd.period   = period_q;
		cmd.id       = next_id;
		unique case (state_q)
			S_ADD: begin
				cmd.add = free_found;
				cmd.idx = free_idx;
			end
			S_REMOVE: begin
				cmd.free = rm_hit;
				cmd.idx  = idx_q;
			end
			S_FIRE: begin
				cmd.idx      = best_idx_q;
				cmd.deadline = rearm_dl;
				cmd.free     = due && release_slot;
				cmd.rearm    = due && !release_slot;
			end
			default: begin
				cmd.idx = idx_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			last_id_q  <= '0;
			done_q     <= 1'b0;
			idx_q      <= '0;
			found_q    <= 1'b0;
			best_hit_q <= 1'b0;
			status_q   <= ptq_pkg::ST_OK;
			new_id_q   <= '0;
			fired_q    <= 1'b0;
			fired_id_q <= '0;
			armed_q    <= 1'b0;
			next_dl_q  <= '0;
		end else begin
			done_q <= (state_q == S_RESP);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q   <= ptq_pkg::ST_OK;
						new_id_q   <= '0;
						fired_q    <= 1'b0;
						fired_id_q <= '0;
						idx_q      <= '0;
						found_q    <= 1'b0;
						best_hit_q <= 1'b0;
						unique case (req_type)
							ptq_pkg::REQ_ADD:    state_q <= S_ADD;
							ptq_pkg::REQ_REMOVE: state_q <= S_REMOVE;
							ptq_pkg::REQ_CHECK:  state_q <= S_SCAN_PRE;
							default:             state_q <= S_SCAN;
						endcase
					end
				end
				S_ADD: begin
					if (free_found) begin
						last_id_q <= next_id;
						new_id_q  <= next_id;
					end else begin
						status_q <= ptq_pkg::ST_FULL;
					end
					state_q <= S_SCAN;
				end
				S_REMOVE: begin
					if (rm_hit)
						found_q <= 1'b1;
					if (last_slot) begin
						idx_q <= '0;
						if (!found_q && !rm_hit)
							status_q <= ptq_pkg::ST_NOT_FOUND;
						state_q <= S_SCAN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SCAN_PRE, S_SCAN: begin
					if (better) begin
						best_hit_q <= 1'b1;
						best_idx_q <= idx_q;
						best_dl_q  <= rd.deadline;
						best_ord_q <= rd.order;
					end
					if (last_slot) begin
						idx_q   <= '0;
						state_q <= (state_q == S_SCAN_PRE) ? S_FIRE : S_RESP;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_FIRE: begin
					if (due) begin
						fired_q    <= 1'b1;
						fired_id_q <= rd.id;
						best_hit_q <= 1'b0;
						state_q    <= S_SCAN;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					armed_q   <= best_hit_q;
					next_dl_q <= best_hit_q ? best_dl_q : '0;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			now_q      <= now_ms;
			deadline_q <= deadline_ms;
			period_q   <= period_ms;
			cid_q      <= cancel_id;
			stop_q     <= handler_stop;
		end
	end

endmodule

@@ tb/timer_queue_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the periodic timer queue: keeps its own copy of the timer slots,
// predicts every result from the accepted requests and compares it when done strobes.
// Depends on ptq_pkg.
module timer_queue_checker
	import ptq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [1:0]        req_type,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [TIME_W-1:0] deadline_ms,
	input  logic [PER_W-1:0]  period_ms,
	input  logic [ID_W-1:0]   cancel_id,
	input  logic              handler_stop,
	input  logic              done,
	input  logic [1:0]        status,
	input  logic [ID_W-1:0]   new_id,
	input  logic              fired,
	input  logic [ID_W-1:0]   fired_id,
	input  logic              armed,
	input  logic [TIME_W-1:0] next_deadline_ms,
	output int                failures,
	output int                outstanding,
	output int                results_seen,
	output int                fires_seen
);

	typedef struct packed {
		logic [1:0]        status;
		logic [ID_W-1:0]   new_id;
		logic              fired;
		logic [ID_W-1:0]   fired_id;
		logic              armed;
		logic [TIME_W-1:0] next_due;
	} timer_result_t;

	logic              slot_used  [MAX_TIMERS];
	logic [TIME_W-1:0] slot_due   [MAX_TIMERS];
	logic [PER_W-1:0]  slot_every [MAX_TIMERS];
	logic [ID_W-1:0]   slot_tag   [MAX_TIMERS];
	logic [15:0]       slot_rank  [MAX_TIMERS];
	logic [15:0]       entry_count;
	logic [ID_W-1:0]   last_issued;

	timer_result_t expected_results [$];
	int            fail_count;
	int            result_count;
	int            fire_count;

	function automatic int earliest_due();
		int best;
		best = -1;
		for (int i = 0; i < MAX_TIMERS; i++)
			if (slot_used[i] && (best < 0 || slot_due[i] < slot_due[best] ||
					(slot_due[i] == slot_due[best] && slot_rank[i] < slot_rank[best])))
				best = i;
		return best;
	endfunction

	task automatic release_slot(input int idx);
		logic [15:0] r;
		r = slot_rank[idx];
		slot_used[idx] = 1'b0;
		for (int k = 0; k < MAX_TIMERS; k++)
			if (slot_used[k] && slot_rank[k] > r)
				slot_rank[k] = slot_rank[k] - 16'd1;
		if (entry_count > 0)
			entry_count = entry_count - 16'd1;
	endtask

	task automatic rank_newest(input int idx);
		logic [15:0] r;
		r = slot_rank[idx];
		for (int k = 0; k < MAX_TIMERS; k++)
			if (k != idx && slot_used[k] && slot_rank[k] > r)
				slot_rank[k] = slot_rank[k] - 16'd1;
		slot_rank[idx] = entry_count - 16'd1;
	endtask

	task automatic predict_request(
		input  logic [1:0]        kind,
		input  logic [TIME_W-1:0] now,
		input  logic [TIME_W-1:0] due,
		input  logic [PER_W-1:0]  every,
		input  logic [ID_W-1:0]   cid,
		input  logic              stop,
		output timer_result_t     res
	);
		int            slot;
		logic [TIME_W:0] rearm_at;
		res = '0;
		case (kind)
			REQ_ADD: begin
				slot = -1;
				for (int i = 0; i < MAX_TIMERS; i++)
					if (!slot_used[i] && slot < 0)
						slot = i;
				if (slot < 0) begin
					res.status = ST_FULL;
				end else begin
					last_issued = last_issued + 1'b1;
					if (last_issued == '0)
						last_issued = 1;
					slot_used[slot]  = 1'b1;
					slot_due[slot]   = due;
					slot_every[slot] = every;
					slot_tag[slot]   = last_issued;
					slot_rank[slot]  = entry_count;
					entry_count      = entry_count + 16'd1;
					res.new_id       = last_issued;
				end
			end
			REQ_REMOVE: begin
				res.status = ST_NOT_FOUND;
				for (int i = 0; i < MAX_TIMERS; i++)
					if (slot_used[i] && slot_tag[i] == cid && cid != '0) begin
						release_slot(i);
						res.status = ST_OK;
					end
			end
			REQ_CHECK: begin
				slot = earliest_due();
				if (slot >= 0 && slot_due[slot] <= now) begin
					res.fired    = 1'b1;
					res.fired_id = slot_tag[slot];
					if (slot_every[slot] == '0 || stop) begin
						release_slot(slot);
					end else begin
						// saturate the re-arm time at the top of the clock range
						rearm_at = {1'b0, now} + slot_every[slot];
						slot_due[slot] = rearm_at[TIME_W] ? '1 : rearm_at[TIME_W-1:0];
						rank_newest(slot);
					end
				end
			end
			default: ;
		endcase
		slot = earliest_due();
		res.armed    = (slot >= 0);
		res.next_due = (slot >= 0) ? slot_due[slot] : '0;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		timer_result_t want, got;
		if (!arst_n) begin
			for (int i = 0; i < MAX_TIMERS; i++) begin
				slot_used[i]  = 1'b0;
				slot_due[i]   = '0;
				slot_every[i] = '0;
				slot_tag[i]   = '0;
				slot_rank[i]  = '0;
			end
			entry_count  = '0;
			last_issued  = '0;
			fail_count   = 0;
			result_count = 0;
			fire_count   = 0;
			expected_results.delete();
			failures     <= 0;
			outstanding  <= 0;
			results_seen <= 0;
			fires_seen   <= 0;
		end else begin
			if (done) begin
				got = '{status, new_id, fired, fired_id, armed, next_deadline_ms};
				result_count++;
				if (fired === 1'b1)
					fire_count++;
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result with no request pending: status %0d new_id %0d",
							$time, status, new_id);
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status || got.new_id !== want.new_id ||
							got.fired !== want.fired || got.fired_id !== want.fired_id ||
							got.armed !== want.armed || got.next_due !== want.next_due) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch, expected status %0d new_id %0d fired %0d",
								$time, want.status, want.new_id, want.fired);
							$display("    fired_id %0d armed %0d next %0d; got status %0d",
								want.fired_id, want.armed, want.next_due, got.status);
							$display("    new_id %0d fired %0d fired_id %0d armed %0d next %0d",
								got.new_id, got.fired, got.fired_id, got.armed, got.next_due);
						end
					end
				end
			end
			if (start && !busy) begin
				predict_request(req_type, now_ms, deadline_ms, period_ms, cancel_id,
					handler_stop, want);
				expected_results.push_back(want);
			end
			failures     <= fail_count;
			outstanding  <= expected_results.size();
			results_seen <= result_count;
			fires_seen   <= fire_count;
		end
	end

endmodule

@@ tb/periodic_timer_queue_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the periodic timer queue: drives directed and random requests
// with random gaps (none in some random phases) and gives the verdict.
// Depends on ptq_pkg, periodic_timer_queue and timer_queue_checker.
module periodic_timer_queue_test;
	import ptq_pkg::*;

	localparam int IDLE_LIMIT  = 1000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 50;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [PER_W-1:0]  PER_MAX  = '1;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              start        = 1'b0;
	logic [1:0]        req_type     = REQ_NONE;
	logic [TIME_W-1:0] now_ms       = '0;
	logic [TIME_W-1:0] deadline_ms  = '0;
	logic [PER_W-1:0]  period_ms    = '0;
	logic [ID_W-1:0]   cancel_id    = '0;
	logic              handler_stop = 1'b0;

	logic              busy;
	logic              done;
	logic [1:0]        status;
	logic [ID_W-1:0]   new_id;
	logic              fired;
	logic [ID_W-1:0]   fired_id;
	logic              armed;
	logic [TIME_W-1:0] next_deadline_ms;

	int                failures;
	int                outstanding;
	int                results_seen;
	int                fires_seen;
	int                idle_cycles = 0;
	int                requests_sent = 0;
	bit                no_gaps = 1'b0;
	logic [ID_W-1:0]   latest_id = '0;
	logic [TIME_W-1:0] clock_ms;

	always #5 clk = ~clk;

	periodic_timer_queue dut (.*);

	timer_queue_checker checker_i (.*);

	// track the newest id so removes mostly hit live timers
	always @(posedge clk)
		if (done && new_id != '0)
			latest_id <= new_id;

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no request or result for %0d cycles", IDLE_LIMIT);
			$display("periodic_timer_queue_test: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [TIME_W-1:0] rand48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[TIME_W-1:0];
	endfunction

	task automatic send(
		input logic [1:0]        kind,
		input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] due,
		input logic [PER_W-1:0]  every,
		input logic [ID_W-1:0]   cid,
		input logic              stop
	);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		req_type     <= kind;
		now_ms       <= now;
		deadline_ms  <= due;
		period_ms    <= every;
		cancel_id    <= cid;
		handler_stop <= stop;
		do @(posedge clk); while (busy);
		requests_sent++;
	endtask

	task automatic random_request(input int add_pct, input int remove_pct);
		int              pick;
		logic [PER_W-1:0] every;
		if ($urandom_range(0, 9) == 0) begin
			send(2'($urandom_range(0, 3)), rand48(), rand48(), $urandom,
				16'($urandom), 1'($urandom));
		end else begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 7))
				0, 1:    every = '0;
				7:       every = $urandom;
				default: every = $urandom_range(1, 120);
			endcase
			if (pick < add_pct) begin
				send(REQ_ADD, rand48(), clock_ms + $urandom_range(0, 150), every,
					16'($urandom), 1'($urandom));
			end else if (pick < add_pct + remove_pct) begin
				send(REQ_REMOVE, rand48(), rand48(), $urandom,
					latest_id - 16'($urandom_range(0, 20)), 1'($urandom));
			end else begin
				clock_ms = clock_ms + $urandom_range(0, 60);
				send(REQ_CHECK, clock_ms, rand48(), $urandom, 16'($urandom),
					$urandom_range(0, 3) == 0);
			end
		end
	endtask

	initial begin
		int add_pct;
		int remove_pct;
		clock_ms = {16'h0, $urandom};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(REQ_CHECK,  rand48(), rand48(), $urandom, 16'($urandom), 1'b1);
		send(REQ_REMOVE, rand48(), rand48(), $urandom, 16'h0000, 1'b0);
		send(REQ_NONE,   rand48(), rand48(), $urandom, 16'($urandom), 1'b1);
		send(REQ_ADD,    rand48(), '0, '0, 16'($urandom), 1'b0);
		send(REQ_ADD,    rand48(), TIME_MAX, PER_MAX, 16'($urandom), 1'b0);
		send(REQ_ADD,    rand48(), 48'd100, 32'd50, 16'($urandom), 1'b0);
		send(REQ_ADD,    rand48(), 48'd100, 32'd7, 16'($urandom), 1'b0);
		send(REQ_CHECK,  '0, rand48(), $urandom, 16'($urandom), 1'b0);
		// equal deadlines: the older entry goes first, the second stops itself
		send(REQ_CHECK,  48'd100, rand48(), $urandom, 16'($urandom), 1'b0);
		send(REQ_CHECK,  48'd100, rand48(), $urandom, 16'($urandom), 1'b1);
		// re-arm beyond the end of the clock range, twice
		send(REQ_CHECK,  TIME_MAX, rand48(), $urandom, 16'($urandom), 1'b0);
		send(REQ_CHECK,  TIME_MAX, rand48(), $urandom, 16'($urandom), 1'b0);
		send(REQ_NONE,   rand48(), rand48(), $urandom, 16'($urandom), 1'b0);
		send(REQ_REMOVE, rand48(), rand48(), $urandom, 16'hFFFF, 1'b1);
		send(REQ_REMOVE, rand48(), rand48(), $urandom, 16'd2, 1'b0);
		send(REQ_REMOVE, rand48(), rand48(), $urandom, 16'd3, 1'b0);

		for (int phase = 0; phase < PHASES; phase++) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if (phase == 0) begin
				add_pct    = 80;
				remove_pct = 5;
			end else begin
				add_pct    = $urandom_range(15, 50);
				remove_pct = $urandom_range(5, 30);
			end
			repeat (PHASE_ITEMS) random_request(add_pct, remove_pct);
		end
		start <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (40) @(posedge clk);

		$display("%0d requests driven: directed extremes, then %0d random phases",
			requests_sent, PHASES);
		$display("%0d results checked, %0d of them fired a timer", results_seen, fires_seen);
		if (failures == 0 && outstanding == 0) begin
			$display("periodic_timer_queue_test: PASS");
		end else begin
			$display("periodic_timer_queue_test: FAIL");
		end
		$finish;
	end

endmodule
